// File: src/gsh_pkg.sv
//------------------------------------------------------------------------------
// gsh_pkg
// Shared types and constants for the Gimli sponge hash block.
//------------------------------------------------------------------------------
package gsh_pkg;

   localparam int unsigned RateBytes  = 16;
   localparam int unsigned StateBytes = 48;
   localparam logic [31:0] RoundConst = 32'h9e377900;
   localparam logic [7:0]  PadByte    = 8'h1f;
   localparam logic [7:0]  EndByte    = 8'h80;

   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_ABSORB  = 2'd1,
      ACT_FINISH  = 2'd2,
      ACT_SQUEEZE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_FINISH_OK = 2'd0,
      ST_BAD_LEN   = 2'd1,
      ST_DIGEST    = 2'd2,
      ST_REJECT    = 2'd3
   } status_type;

   // Classified request handed from the front to the back.
   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_ABSORB,
      OP_FINISH,
      OP_SQUEEZE,
      OP_STATUS
   } op_type;

   typedef struct packed {
      op_type      op;
      status_type  status;
      logic [7:0]  data;
      logic [15:0] length;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PERM,
      BK_FIN,
      BK_PAD,
      BK_EMIT,
      BK_STAT
   } back_state_type;

   typedef logic [31:0] word_array_type [12];

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   // One Gimli round, r is the round counter value.
   function automatic word_array_type gimli_round(input word_array_type s,
                                                  input logic [4:0] r);
      word_array_type o;
      logic [31:0] x, y, z, t;
      o = s;
      for (int j = 0; j < 4; j++) begin
         x = rotl(s[j], 24);
         y = rotl(s[4 + j], 9);
         z = s[8 + j];
         o[8 + j] = x ^ (z << 1) ^ ((y & z) << 2);
         o[4 + j] = y ^ x ^ ((x | z) << 1);
         o[j]     = z ^ y ^ ((x & y) << 3);
      end
      if (r[1:0] == 2'd0) begin
         t = o[0]; o[0] = o[1]; o[1] = t;
         t = o[2]; o[2] = o[3]; o[3] = t;
         o[0] = o[0] ^ RoundConst ^ {27'd0, r};
      end else if (r[1:0] == 2'd2) begin
         t = o[0]; o[0] = o[2]; o[2] = t;
         t = o[1]; o[1] = o[3]; o[3] = t;
      end
      gimli_round = o;
   endfunction

endpackage

// File: src/gsh_front.sv
//------------------------------------------------------------------------------
// gsh_front
// Accepts requests, tracks the phase and classifies each one.
//------------------------------------------------------------------------------
module gsh_front #(
   parameter int unsigned MIN_OUT_BYTES = 16,
   parameter int unsigned MAX_OUT_BYTES = 65535
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [7:0]          req_data_byte,
   input  logic [15:0]         req_output_length,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output gsh_pkg::cmd_type    cmd
);

   logic        finished_ff, finished_in;
   logic [15:0] remain_ff, remain_in;
   logic        bad_len;
   logic [15:0] take;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;

   assign bad_len = (32'(req_output_length) < 32'(MIN_OUT_BYTES)) ||
                    (32'(req_output_length) > 32'(MAX_OUT_BYTES));
   assign take = (remain_ff < 16'(gsh_pkg::StateBytes)) ? remain_ff
                                                       : 16'(gsh_pkg::StateBytes);

   always_comb begin
      cmd.op     = gsh_pkg::OP_STATUS;
      cmd.status = gsh_pkg::ST_REJECT;
      cmd.data   = req_data_byte;
      cmd.length = req_output_length;
      finished_in = finished_ff;
      remain_in   = remain_ff;
      unique case (gsh_pkg::action_type'(req_action))
         gsh_pkg::ACT_CLEAR: begin
            cmd.op = gsh_pkg::OP_CLEAR;
            finished_in = 1'b0;
            remain_in = '0;
         end
         gsh_pkg::ACT_ABSORB: begin
            if (!finished_ff) cmd.op = gsh_pkg::OP_ABSORB;
         end
         gsh_pkg::ACT_FINISH: begin
            if (!finished_ff) begin
               if (bad_len) begin
                  cmd.status = gsh_pkg::ST_BAD_LEN;
               end else begin
                  cmd.op = gsh_pkg::OP_FINISH;
                  finished_in = 1'b1;
                  remain_in = req_output_length;
               end
            end
         end
         default: begin
            if (finished_ff && remain_ff != '0) begin
               cmd.op = gsh_pkg::OP_SQUEEZE;
               cmd.length = take;
               remain_in = remain_ff - take;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finished_ff <= 1'b0;
         remain_ff   <= '0;
      end else if (req_valid && req_ready) begin
         finished_ff <= finished_in;
         remain_ff   <= remain_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_remain_idle: assert property (@(posedge clock) disable iff (reset)
      !finished_ff |-> remain_ff == '0) else $error("remaining count without finish");
   a_squeeze_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd.op == gsh_pkg::OP_SQUEEZE |-> cmd.length != '0)
      else $error("empty squeeze");
   a_reject_ok: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd.op == gsh_pkg::OP_STATUS |->
      (cmd.status == gsh_pkg::ST_REJECT || cmd.status == gsh_pkg::ST_BAD_LEN))
      else $error("bad status class");
`endif

endmodule

// File: src/gsh_queue.sv
//------------------------------------------------------------------------------
// gsh_queue
// Two-entry command queue between the front and back parts.
//------------------------------------------------------------------------------
module gsh_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  gsh_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output gsh_pkg::cmd_type out_cmd
);

   gsh_pkg::cmd_type slot_ff [2];
   logic             wptr_ff, rptr_ff;
   logic [1:0]       count_ff;
   logic             push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_cmd   = slot_ff[rptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= in_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wptr_ff == rptr_ff)
      else $error("queue pointers disagree");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop && count_ff == 2'd1 |=> count_ff == 2'd2)
      else $error("queue count not advanced");
`endif

endmodule

// File: src/gsh_back.sv
//------------------------------------------------------------------------------
// gsh_back
// Runs absorb, pad, permutation and squeeze, and drives the result register.
//------------------------------------------------------------------------------
module gsh_back #(
   parameter int unsigned PERM_ROUNDS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  gsh_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_digest_byte,
   output logic             rsp_last
);

   gsh_pkg::back_state_type state_ff, state_in;
   gsh_pkg::word_array_type words_ff, words_in;
   gsh_pkg::cmd_type        cur_ff, cur_in;
   logic [4:0]  pos_ff, pos_in;       // 0..16
   logic [4:0]  round_ff, round_in;
   logic [2:0]  step_ff, step_in;     // finish byte index
   logic [5:0]  idx_ff, idx_in;       // squeeze byte index
   logic        after_ff, after_in;   // emit after permute, else resume absorb or finish
   logic [7:0]  pend_ff, pend_in;     // byte waiting for the permute
   logic        rv_ff, rv_in;
   logic [1:0]  rs_ff, rs_in;
   logic [7:0]  rd_ff, rd_in;
   logic        rl_ff, rl_in;
   logic        out_free;
   logic [7:0]  fin_byte;
   logic        fin_done;
   logic [7:0]  hi, lo;

   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_digest_byte = rd_ff;
   assign rsp_last = rl_ff;
   assign out_free = !rv_ff || rsp_ready;
   assign hi = cur_ff.length[15:8];
   assign lo = cur_ff.length[7:0];

   // length encoding: count, low byte, high byte when nonzero, then a zero byte
   always_comb begin
      unique case (step_ff)
         3'd0:    fin_byte = (hi != 8'd0) ? 8'd2 : 8'd1;
         3'd1:    fin_byte = lo;
         3'd2:    fin_byte = (hi != 8'd0) ? hi : 8'd0;
         default: fin_byte = 8'd0;
      endcase
      fin_done = (step_ff == 3'd4) || (step_ff == 3'd3 && hi == 8'd0);
   end

   function automatic gsh_pkg::word_array_type xor_at(input gsh_pkg::word_array_type s,
                                                      input logic [5:0] k,
                                                      input logic [7:0] v);
      gsh_pkg::word_array_type o;
      o = s;
      if (k < 6'(gsh_pkg::StateBytes))
         o[k[5:2]] = s[k[5:2]] ^ ({24'd0, v} << {k[1:0], 3'd0});
      xor_at = o;
   endfunction

   always_comb begin
      logic [31:0] w;
      state_in = state_ff;
      words_in = words_ff;
      cur_in = cur_ff;
      pos_in = pos_ff;
      round_in = round_ff;
      step_in = step_ff;
      idx_in = idx_ff;
      after_in = after_ff;
      pend_in = pend_ff;
      rv_in = rv_ff && !rsp_ready;
      rs_in = rs_ff;
      rd_in = rd_ff;
      rl_in = rl_ff;
      cmd_ready = 1'b0;
      w = words_ff[idx_ff[5:2]];
      unique case (state_ff)
         gsh_pkg::BK_IDLE: begin
            cmd_ready = out_free;
            if (cmd_valid && out_free) begin
               cur_in = cmd;
               unique case (cmd.op)
                  gsh_pkg::OP_CLEAR: begin
                     for (int i = 0; i < 12; i++) words_in[i] = '0;
                     pos_in = '0;
                  end
                  gsh_pkg::OP_ABSORB: begin
                     if (pos_ff >= 5'(gsh_pkg::RateBytes)) begin
                        pend_in = cmd.data;
                        after_in = 1'b0;
                        round_in = 5'(PERM_ROUNDS);
                        state_in = gsh_pkg::BK_PERM;
                     end else begin
                        words_in = xor_at(words_ff, {1'b0, pos_ff}, cmd.data);
                        pos_in = pos_ff + 5'd1;
                     end
                  end
                  gsh_pkg::OP_FINISH: begin
                     step_in = 3'd0;
                     state_in = gsh_pkg::BK_FIN;
                  end
                  gsh_pkg::OP_SQUEEZE: begin
                     idx_in = '0;
                     after_in = 1'b1;
                     round_in = 5'(PERM_ROUNDS);
                     state_in = gsh_pkg::BK_PERM;
                  end
                  default: begin
                     rv_in = 1'b1;
                     rs_in = cmd.status;
                     rd_in = '0;
                     rl_in = 1'b1;
                  end
               endcase
            end
         end
         gsh_pkg::BK_PERM: begin
            // one round a cycle, counting down
            words_in = gsh_pkg::gimli_round(words_ff, round_ff);
            round_in = round_ff - 5'd1;
            if (round_ff == 5'd1) begin
               if (after_ff) begin
                  state_in = gsh_pkg::BK_EMIT;
               end else begin
                  words_in = xor_at(gsh_pkg::gimli_round(words_ff, round_ff), 6'd0, pend_ff);
                  pos_in = 5'd1;
                  state_in = (cur_ff.op == gsh_pkg::OP_FINISH) ? gsh_pkg::BK_FIN
                                                               : gsh_pkg::BK_IDLE;
                  if (cur_ff.op == gsh_pkg::OP_FINISH) step_in = step_ff + 3'd1;
               end
            end
         end
         gsh_pkg::BK_FIN: begin
            if (fin_done) begin
               state_in = gsh_pkg::BK_PAD;
            end else if (pos_ff >= 5'(gsh_pkg::RateBytes)) begin
               pend_in = fin_byte;
               after_in = 1'b0;
               round_in = 5'(PERM_ROUNDS);
               state_in = gsh_pkg::BK_PERM;
            end else begin
               words_in = xor_at(words_ff, {1'b0, pos_ff}, fin_byte);
               pos_in = pos_ff + 5'd1;
               step_in = step_ff + 3'd1;
            end
         end
         gsh_pkg::BK_PAD: begin
            if (out_free) begin
               words_in = xor_at(xor_at(words_ff, {1'b0, pos_ff}, gsh_pkg::PadByte),
                                 6'(gsh_pkg::RateBytes - 1), gsh_pkg::EndByte);
               rv_in = 1'b1;
               rs_in = gsh_pkg::ST_FINISH_OK;
               rd_in = '0;
               rl_in = 1'b1;
               state_in = gsh_pkg::BK_IDLE;
            end
         end
         gsh_pkg::BK_EMIT: begin
            if (out_free) begin
               rv_in = 1'b1;
               rs_in = gsh_pkg::ST_DIGEST;
               rd_in = w[{idx_ff[1:0], 3'd0} +: 8];
               rl_in = (16'(idx_ff) + 16'd1 == cur_ff.length);
               idx_in = idx_ff + 6'd1;
               if (16'(idx_ff) + 16'd1 == cur_ff.length) state_in = gsh_pkg::BK_IDLE;
            end
         end
         default: state_in = gsh_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsh_pkg::BK_IDLE;
         rv_ff    <= 1'b0;
         pos_ff   <= '0;
         for (int i = 0; i < 12; i++) words_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         pos_ff   <= pos_in;
         words_ff <= words_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      round_ff <= round_in;
      step_ff  <= step_in;
      idx_ff   <= idx_in;
      after_ff <= after_in;
      pend_ff  <= pend_in;
      rs_ff    <= rs_in;
      rd_ff    <= rd_in;
      rl_ff    <= rl_in;
   end

`ifndef NO_ASSERTIONS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= 5'(gsh_pkg::RateBytes)) else $error("rate position out of range");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff && $stable(rd_ff)) else $error("result dropped");
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == gsh_pkg::BK_EMIT |-> idx_ff < 6'(gsh_pkg::StateBytes))
      else $error("squeeze index past state");
`endif

endmodule

// File: src/gimli_sponge_hash.sv
//------------------------------------------------------------------------------
// gimli_sponge_hash
// Byte-serial Gimli sponge hash: request front, command queue, sponge engine.
//------------------------------------------------------------------------------
// Usage:
//   Requests (req_*) carry an action: clear, absorb a byte, finish with a
//   digest length, or squeeze one block. Results (rsp_*) carry a status, a
//   digest byte and a last flag on the final result of each request.
//   Clear and absorb give no result; finish and rejects give one; a squeeze
//   gives up to 48 digest bytes, one per cycle while the receiver accepts.
//   An absorb XORs its byte into the state; when the 16-byte rate is full,
//   it first runs PERM_ROUNDS rounds of the permutation (one round per cycle
//   in the engine). Finish absorbs the length encoding, permuting at each
//   full rate, then pads and gives its result; a squeeze runs the permutation,
//   then emits its bytes.
//   A two-entry queue lets the front accept while the engine is busy.
//   Reset clears the state, phase and queue. A stalled receiver holds the
//   result register; the engine and then the queue stop in turn.
//------------------------------------------------------------------------------
module gimli_sponge_hash #(
   parameter int unsigned MIN_OUT_BYTES = 16,
   parameter int unsigned MAX_OUT_BYTES = 65535,
   parameter int unsigned PERM_ROUNDS   = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_output_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_digest_byte,
   output logic        rsp_last
);

   logic             f_valid, f_ready, b_valid, b_ready;
   gsh_pkg::cmd_type f_cmd, b_cmd;

   gsh_front #(.MIN_OUT_BYTES(MIN_OUT_BYTES), .MAX_OUT_BYTES(MAX_OUT_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_data_byte,
      .req_output_length, .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   gsh_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
      .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
   );

   gsh_back #(.PERM_ROUNDS(PERM_ROUNDS)) u_back (
      .clock, .reset, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_digest_byte, .rsp_last
   );

endmodule
